/* src/stss_pkg.sv */
package stss_pkg;

    localparam int DEF_TABLE_DEPTH = 256;

    localparam int       SIZE_W     = 9;
    localparam int       INDEX_W    = 8;
    localparam int       VALUE_W    = 32;
    localparam int       POS_W      = 8;
    localparam bit [8:0] SIZE_RESET = 9'd256;

    localparam bit OP_WRITE  = 1'b0;
    localparam bit OP_SEARCH = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the input transaction
        logic write;     // store the latched entry
        logic rd_mid;    // read the middle entry
        logic check;     // compare with the middle entry, set up the scan
        logic scan;      // one scan step
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op_search;
        logic mid_hit;
        logic scan_hit;
        logic scan_end;
    } sts_t;

endpackage

/* src/sorted_table_half_scan_search_unit.sv */
// Sorted table search unit.
// Command channel: a transaction is taken when start is high and busy is low.
// op selects a table write (entry_index, entry_value) or a search (search_key).
// A write gives no result.
// A search reads the middle entry (table_size/2) from the table RAM, then on a
// miss scans one half, one RAM read per cycle with the compare in the next cycle.
// A search passes through the probe, check and done states on a middle hit,
// with the scan state between check and done otherwise; busy drops in the
// cycle after the strobe. The single-ported RAM scan sets the length of a miss.
// Result: found and position are valid for exactly one cycle while
// result_valid is high; the receiver cannot stall, so there is no back-pressure.
// position is 0 when the key is not found.
// Config: cfg_valid/cfg_ready write table_size (values 0 and above TABLE_DEPTH
// are clamped); cfg_ready is high while the unit is idle.
// Reset: table_size returns to 256, the controller goes idle; table contents
// are not cleared and must be written before they are searched.
module sorted_table_half_scan_search_unit #(
    parameter int TABLE_DEPTH = stss_pkg::DEF_TABLE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 op,
    input  logic [stss_pkg::INDEX_W-1:0]         entry_index,
    input  logic signed [stss_pkg::VALUE_W-1:0]  entry_value,
    input  logic signed [stss_pkg::VALUE_W-1:0]  search_key,
    output logic                                 result_valid,
    output logic                                 found,
    output logic [stss_pkg::POS_W-1:0]           position,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [stss_pkg::SIZE_W-1:0]          cfg_data
);

    stss_pkg::cmd_t cmd;
    stss_pkg::sts_t sts;

    assign cfg_ready = !busy;

    stss_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .sts          (sts),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    stss_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .op          (op),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .found       (found),
        .position    (position)
    );

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");

    a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !found) |-> (position == '0))
        else $error("miss reported with nonzero position");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == stss_pkg::OP_WRITE) |=> ##1 !result_valid)
        else $error("write transaction produced a result");

endmodule

/* src/stss_ram.sv */
module stss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/stss_datapath.sv */
module stss_datapath #(
    parameter int TABLE_DEPTH = stss_pkg::DEF_TABLE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  stss_pkg::cmd_t                       cmd,
    output stss_pkg::sts_t                       sts,
    input  logic                                 op,
    input  logic [stss_pkg::INDEX_W-1:0]         entry_index,
    input  logic signed [stss_pkg::VALUE_W-1:0]  entry_value,
    input  logic signed [stss_pkg::VALUE_W-1:0]  search_key,
    input  logic                                 cfg_we,
    input  logic [stss_pkg::SIZE_W-1:0]          cfg_data,
    output logic                                 found,
    output logic [stss_pkg::POS_W-1:0]           position
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int SW = $clog2(TABLE_DEPTH + 1);

    logic [stss_pkg::SIZE_W-1:0]         table_size_reg, table_size_next;
    logic [stss_pkg::INDEX_W-1:0]        idx_reg, idx_next;
    logic signed [stss_pkg::VALUE_W-1:0] val_reg, val_next;
    logic signed [stss_pkg::VALUE_W-1:0] key_reg, key_next;
    logic [AW-1:0]                       ptr_reg, ptr_next;
    logic [SW-1:0]                       cnt_reg, cnt_next;
    logic [AW-1:0]                       cmp_addr_reg, cmp_addr_next;
    logic                                cmp_vld_reg, cmp_vld_next;
    logic                                dir_up_reg, dir_up_next;
    logic                                found_reg, found_next;
    logic [AW-1:0]                       pos_reg, pos_next;

    logic [31:0]                         size32;
    logic [SW-1:0]                       size_eff;
    logic [SW-1:0]                       mid_s;
    logic [SW-1:0]                       last_s;
    logic [AW-1:0]                       mid_a;
    logic [AW-1:0]                       last_a;
    logic [31:0]                         idx32;
    logic [31:0]                         pos32;
    logic                                in_range;
    logic                                key_eq;
    logic                                key_lt;
    logic                                scan_hit;
    logic                                issue;
    logic                                ram_we;
    logic                                ram_re;
    logic [AW-1:0]                       ram_raddr;
    logic signed [stss_pkg::VALUE_W-1:0] rdata;

    // effective size: zero acts as one, clamp to the table depth
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            size32 = 32'd1;
        end
        else if (32'(table_size_reg) > 32'(TABLE_DEPTH))
        begin
            size32 = 32'(TABLE_DEPTH);
        end
        else
        begin
            size32 = 32'(table_size_reg);
        end
    end

    assign size_eff = size32[SW-1:0];
    assign mid_s    = size_eff >> 1;
    assign last_s   = size_eff - SW'(1);
    assign mid_a    = mid_s[AW-1:0];
    assign last_a   = last_s[AW-1:0];

    assign idx32    = 32'(idx_reg);
    assign in_range = idx32 < 32'(TABLE_DEPTH);

    assign key_eq   = (rdata == key_reg);
    assign key_lt   = (key_reg < rdata);
    assign scan_hit = cmp_vld_reg && key_eq;
    assign issue    = !scan_hit && (cnt_reg != '0);

    assign ram_we    = cmd.write && in_range;
    assign ram_re    = cmd.rd_mid || (cmd.scan && issue);
    assign ram_raddr = cmd.rd_mid ? mid_a : ptr_reg;

    stss_ram #(
        .WIDTH (stss_pkg::VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx32[AW-1:0]),
        .wdata (val_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    assign sts.op_search = (op == stss_pkg::OP_SEARCH);
    assign sts.mid_hit   = key_eq;
    assign sts.scan_hit  = scan_hit;
    assign sts.scan_end  = !scan_hit && (cnt_reg == '0);

    always_comb
    begin
        table_size_next = cfg_we ? cfg_data : table_size_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        key_next        = key_reg;
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        cmp_addr_next   = cmp_addr_reg;
        cmp_vld_next    = cmp_vld_reg;
        dir_up_next     = dir_up_reg;
        found_next      = found_reg;
        pos_next        = pos_reg;

        if (cmd.capture)
        begin
            idx_next   = entry_index;
            val_next   = entry_value;
            key_next   = search_key;
            found_next = 1'b0;
            pos_next   = '0;
        end

        if (cmd.check)
        begin
            cmp_vld_next = 1'b0;
            if (key_eq)
            begin
                found_next = 1'b1;
                pos_next   = mid_a;
            end
            else
            begin
                // smaller key scans the lower half upward, else the upper half downward
                dir_up_next = key_lt;
                ptr_next    = key_lt ? '0 : last_a;
                cnt_next    = key_lt ? mid_s : (last_s - mid_s);
            end
        end

        if (cmd.scan)
        begin
            if (scan_hit)
            begin
                found_next = 1'b1;
                pos_next   = cmp_addr_reg;
            end
            else if (issue)
            begin
                cmp_vld_next  = 1'b1;
                cmp_addr_next = ptr_reg;
                ptr_next      = dir_up_reg ? ptr_reg + AW'(1) : ptr_reg - AW'(1);
                cnt_next      = cnt_reg - SW'(1);
            end
            else
            begin
                cmp_vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= stss_pkg::SIZE_RESET;
            cnt_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            dir_up_reg     <= 1'b0;
            found_reg      <= 1'b0;
            pos_reg        <= '0;
        end
        else
        begin
            table_size_reg <= table_size_next;
            cnt_reg        <= cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            dir_up_reg     <= dir_up_next;
            found_reg      <= found_next;
            pos_reg        <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        key_reg      <= key_next;
        ptr_reg      <= ptr_next;
        cmp_addr_reg <= cmp_addr_next;
    end

    assign pos32    = 32'(pos_reg);
    assign found    = found_reg;
    assign position = pos32[stss_pkg::POS_W-1:0];

endmodule

/* src/stss_ctrl.sv */
module stss_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  stss_pkg::sts_t sts,
    output stss_pkg::cmd_t cmd,
    output logic           busy,
    output logic           result_valid
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRITE = 3'd1;
    localparam logic [2:0] S_PROBE = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = sts.op_search ? S_PROBE : S_WRITE;
                end
            end
            S_WRITE: state_next = S_IDLE;
            S_PROBE: state_next = S_CHECK;
            S_CHECK: state_next = sts.mid_hit ? S_DONE : S_SCAN;
            S_SCAN:
            begin
                if (sts.scan_hit || sts.scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.capture   = (state_reg == S_IDLE) && start;
    assign cmd.write     = (state_reg == S_WRITE);
    assign cmd.rd_mid    = (state_reg == S_PROBE);
    assign cmd.check     = (state_reg == S_CHECK);
    assign cmd.scan      = (state_reg == S_SCAN);
    assign busy          = (state_reg != S_IDLE);
    assign result_valid  = (state_reg == S_DONE);

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_PERIOD    = 8;
    localparam int DEPTH         = stss_pkg::DEF_TABLE_DEPTH;
    localparam int INDEX_W       = stss_pkg::INDEX_W;
    localparam int VALUE_W       = stss_pkg::VALUE_W;
    localparam int POS_W         = stss_pkg::POS_W;
    localparam int SIZE_W        = stss_pkg::SIZE_W;
    localparam int SETTLE_CYCLES = 8;     // a table write gives no strobe
    localparam int DRAIN_CYCLES  = 20;
    localparam int STALL_LIMIT   = 4000;  // the worst search scans half the table
    localparam int ITEM_TARGET   = 1000;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic                       op;
        logic [INDEX_W-1:0]         index;
        logic signed [VALUE_W-1:0]  value;
        logic signed [VALUE_W-1:0]  key;
    } table_cmd_t;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
    } lookup_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic                       op = stss_pkg::OP_WRITE;
    logic [INDEX_W-1:0]         entry_index = '0;
    logic signed [VALUE_W-1:0]  entry_value = '0;
    logic signed [VALUE_W-1:0]  search_key = '0;
    logic                       result_valid;
    logic                       found;
    logic [POS_W-1:0]           position;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [SIZE_W-1:0]          cfg_data = '0;

    // stimulus side
    table_cmd_t                 pending_cmds[$];
    table_cmd_t                 next_cmd;
    logic signed [VALUE_W-1:0]  gen_table [DEPTH];
    bit                         gen_written [DEPTH];
    int                         gen_span = DEPTH;
    int                         gap_left = 0;
    bit                         calm = 1'b0;
    bit                         cmd_accepted = 1'b0;

    // predictor side
    logic signed [VALUE_W-1:0]  table_model [DEPTH];
    logic [SIZE_W-1:0]          table_size_q = stss_pkg::SIZE_RESET;
    lookup_t                    expected_lookups[$];
    lookup_t                    want;

    int n_items = 0;
    int n_writes = 0;
    int n_searches = 0;
    int n_hits = 0;
    int n_sizes = 0;
    int mismatch_count = 0;
    int stall_cycles = 0;

    sorted_table_half_scan_search_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .search_key   (search_key),
        .result_valid (result_valid),
        .found        (found),
        .position     (position),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // 0 acts as 1, anything above the depth acts as the depth
    function automatic int span_of(logic [SIZE_W-1:0] size_reg);
        if (size_reg == 0)
            return 1;
        if (size_reg > DEPTH)
            return DEPTH;
        return int'(size_reg);
    endfunction

    function automatic lookup_t lookup_key(logic signed [VALUE_W-1:0] key,
                                           logic [SIZE_W-1:0] size_reg);
        int      span;
        int      mid;
        lookup_t r;
        span = span_of(size_reg);
        mid = span / 2;
        r = '0;
        if (table_model[mid] == key)
        begin
            r.found = 1'b1;
            r.position = POS_W'(mid);
        end
        else if (key < table_model[mid])
        begin
            for (int i = 0; i < mid; i++)
            begin
                if (table_model[i] == key)
                begin
                    r.found = 1'b1;
                    r.position = POS_W'(i);
                    break;
                end
            end
        end
        else
        begin
            for (int i = span - 1; i > mid; i--)
            begin
                if (table_model[i] == key)
                begin
                    r.found = 1'b1;
                    r.position = POS_W'(i);
                    break;
                end
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic add_write(int idx, logic signed [VALUE_W-1:0] val);
        table_cmd_t c;
        c.op = stss_pkg::OP_WRITE;
        c.index = INDEX_W'(idx);
        c.value = val;
        c.key = $urandom;
        pending_cmds.push_back(c);
        gen_table[idx] = val;
        gen_written[idx] = 1'b1;
        n_items++;
    endtask

    task automatic add_search(logic signed [VALUE_W-1:0] key);
        table_cmd_t c;
        c.op = stss_pkg::OP_SEARCH;
        c.index = INDEX_W'($urandom);
        c.value = $urandom;
        c.key = key;
        pending_cmds.push_back(c);
        n_items++;
    endtask

    // mostly keys that sit in the table, some near misses and extremes
    function automatic logic signed [VALUE_W-1:0] pick_key();
        int                         r;
        logic signed [VALUE_W-1:0]  k;
        r = $urandom_range(0, 9);
        k = gen_table[$urandom_range(0, gen_span - 1)];
        if (r == 5)
            k = k + 1;
        else if (r == 6)
            k = k - 1;
        else if (r == 7)
            k = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        else if (r >= 8)
            k = $urandom;
        return k;
    endfunction

    // table_size only changes with the unit idle and nothing outstanding
    task automatic set_size(logic [SIZE_W-1:0] v);
        while (pending_cmds.size() != 0 || start || expected_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        gen_span = span_of(v);
        n_sizes++;
    endtask

    // driver: hold a transaction until taken, then an optional gap
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left <= 0;
        end
        else if (!start || cmd_accepted)
        begin
            if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_cmds.size() != 0)
            begin
                next_cmd = pending_cmds.pop_front();
                start <= 1'b1;
                op <= next_cmd.op;
                entry_index <= next_cmd.index;
                entry_value <= next_cmd.value;
                search_key <= next_cmd.key;
                if ($urandom_range(0, 39) == 0)
                    calm <= !calm;
                gap_left <= calm ? 0 : $urandom_range(0, 18);
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: predict on each accepted transaction, check each strobe
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_accepted <= 1'b0;
            table_size_q <= stss_pkg::SIZE_RESET;
        end
        else
        begin
            cmd_accepted <= start && !busy;
            if (cfg_valid && cfg_ready)
                table_size_q <= cfg_data;
            if (start && !busy)
            begin
                if (op == stss_pkg::OP_WRITE)
                begin
                    table_model[entry_index] = entry_value;
                    n_writes++;
                end
                else
                begin
                    expected_lookups.push_back(lookup_key(search_key, table_size_q));
                    n_searches++;
                end
            end
            if (result_valid)
            begin
                if (expected_lookups.size() == 0)
                begin
                    note_mismatch($sformatf("result with none expected: found=%0b position=%0d",
                                            found, position));
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    if (want.found)
                        n_hits++;
                    if (found !== want.found || position !== want.position)
                        note_mismatch($sformatf(
                            "expected found=%0b position=%0d, got found=%0b position=%0d",
                            want.found, want.position, found, position));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        int                         style;
        int                         r;
        int                         n;
        logic signed [VALUE_W-1:0]  v;
        logic [SIZE_W-1:0]          size_reg;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // single entry table: middle hit, key below, key above
        set_size(1);
        add_write(0, 0);
        add_search(0);
        add_search(32'sh8000_0000);
        add_search(32'sh7FFF_FFFF);
        add_write(255, 32'sh8000_0000);
        // size 0 behaves as size 1
        set_size(0);
        add_search(0);
        add_search(5);
        // two entries: lower half is entry 0 alone
        set_size(2);
        add_write(0, 32'sh8000_0000);
        add_write(1, 100);
        add_search(32'sh8000_0000);
        add_search(100);
        add_search(32'sh7FFF_FFFF);
        add_search(-5);
        set_size(3);
        add_write(2, 32'sh7FFF_FFFF);
        add_search(32'sh7FFF_FFFF);
        add_search(50);
        // duplicates and an unsorted table
        add_write(0, 7);
        add_write(2, 7);
        add_search(7);
        add_write(1, 9);
        add_search(7);
        add_search(9);

        // largest register value acts as the full depth; fill the whole table sorted
        set_size(9'h1FF);
        v = 32'sh8000_0000 + $urandom_range(0, 1 << 30);
        for (int i = 0; i < DEPTH; i++)
        begin
            add_write(i, v);
            v = v + $urandom_range(1, 1 << 23);
        end
        repeat (6) add_search(pick_key());

        while (n_items < ITEM_TARGET)
        begin
            r = $urandom_range(0, 9);
            if (r <= 5)
                size_reg = SIZE_W'($urandom_range(1, 24));
            else if (r <= 7)
                size_reg = SIZE_W'($urandom_range(25, 255));
            else if (r == 8)
                size_reg = SIZE_W'(DEPTH);
            else
                size_reg = $urandom_range(0, 3) == 0 ? '0
                                                     : SIZE_W'($urandom_range(257, 511));
            set_size(size_reg);

            if (gen_span <= 24)
            begin
                // fresh contents: sorted, sorted with repeats, or scrambled
                style = $urandom_range(0, 9);
                v = $urandom;
                for (int i = 0; i < gen_span; i++)
                begin
                    add_write(i, style == 9 ? $signed($urandom) : v);
                    v = v + (style >= 7 ? $urandom_range(0, 1) : $urandom_range(1, 5000));
                end
            end
            else
            begin
                n = $urandom_range(0, 6);
                repeat (n) add_write($urandom_range(0, gen_span - 1), $urandom);
            end
            for (int i = 0; i < gen_span; i++)
                if (!gen_written[i])
                    add_write(i, $urandom);

            n = $urandom_range(8, 20);
            repeat (n)
            begin
                if ($urandom_range(0, 7) == 0)
                    add_write($urandom_range(0, DEPTH - 1), $urandom);
                add_search(pick_key());
            end
        end

        while (pending_cmds.size() != 0 || start || expected_lookups.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d table writes and %0d searches (%0d found) over %0d size settings",
                 n_writes, n_searches, n_hits, n_sizes);
        $display("%0d mismatches in total", mismatch_count);
        if (mismatch_count == 0 && expected_lookups.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
